// ----- hw/rtl/dark_channel_min_filter_assert.svh -----
// Assertion macros shared by the dark channel filter RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef DARK_CHANNEL_MIN_FILTER_ASSERT_SVH
`define DARK_CHANNEL_MIN_FILTER_ASSERT_SVH

// Same-cycle implication.
`define DCMF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DCMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dcmf_pkg.sv -----
// ----------------------------------------------------------------------------
// dcmf_pkg
// Types and constants of the dark channel minimum filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcmf_pkg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] dark_value;
        logic       frame_end;
    } result_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

    localparam logic [11:0] RESET_WIDTH  = 12'd640;
    localparam logic [11:0] RESET_HEIGHT = 12'd480;
    localparam logic [3:0]  RESET_RADIUS = 4'd7;

    // Extended raster positions stay below 4095 + 15.
    localparam int POS_W = 13;

    localparam int HEIGHT_MAX = 2048;

    localparam logic [7:0] FILL_VALUE = 8'hFF;

endpackage

`default_nettype wire

// ----- hw/rtl/dark_channel_min_filter.sv -----
// ----------------------------------------------------------------------------
// dark_channel_min_filter
// Dark channel of an RGB stream: per-pixel channel minimum, then minimum over
// a square window, fed as an extended raster padded by the window radius.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive on pix_valid/pix_stall/pix_data, one transfer per position of
// an extended raster of (height + radius) rows by (width + radius) columns.
// Results leave on dark_valid/dark_stall/dark_data; the transfer at extended
// position (y, x) with y and x at least radius gives pixel (y - radius,
// x - radius), and frame_end marks the frame's last pixel.
// Configuration writes use cfg_valid/cfg_ready (always ready) while the block
// is idle; each write to a named register restarts the frame.
// A result passes the stage registers s1 to s4 and the output register before
// it shows on dark_valid. One pixel is accepted every cycle while pix_stall is
// low: the column history is a simple dual-port memory, one word per column,
// read when a pixel is accepted and rewritten as the pixel leaves the first
// stage, with forwarding when a column is read in the cycle it is written
// (one-column frames with radius zero).
// Reset restores 640 x 480 with radius 7 and restarts the raster; the memory
// needs no clearing pass since rows of an earlier frame are masked out.
// When dark_stall holds a result, the five-stage pipeline keeps filling its
// empty stages and only then raises pix_stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dark_channel_min_filter_assert.svh"

module dark_channel_min_filter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 15
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                pix_valid,
    output logic                                     pix_stall,
    input  wire dcmf_pkg::pixel_t                    pix_data,
    output logic                                     dark_valid,
    input  wire logic                                dark_stall,
    output dcmf_pkg::result_t                        dark_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dcmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dcmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int SR    = 2 * MAX_RADIUS;
    localparam int RAD_W = $clog2(MAX_RADIUS + 1);
    localparam int LIM_W = $clog2(2 * MAX_RADIUS + 2);
    localparam int PW    = dcmf_pkg::POS_W;

    typedef struct packed {
        logic [7:0]       v;
        logic [LIM_W-1:0] vlim;
        logic [LIM_W-1:0] hlim;
        logic             emit;
        logic             fend;
        logic             in_col;
        logic [AW-1:0]    addr;
    } s1_t;

    typedef struct packed {
        logic [LIM_W-1:0] hlim;
        logic             emit;
        logic             fend;
    } side_t;

    // Configuration and raster position.
    logic [11:0]    width_reg;
    logic [11:0]    height_reg;
    logic [3:0]     radius_reg;
    logic [PW-1:0]  col_reg;
    logic [PW-1:0]  col_next;
    logic [PW-1:0]  row_reg;
    logic [PW-1:0]  row_next;
    logic           cfg_hit;

    logic [PW-1:0]    eff_w;
    logic [PW-1:0]    eff_h;
    logic [RAD_W-1:0] eff_r;
    logic [RAD_W:0]   two_r;
    logic [PW-1:0]    span_w;
    logic [PW-1:0]    span_h;

    // Pipeline control.
    logic en1, en2, en3, en4, en5;
    logic accept;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic out_vld_reg;
    logic fend_reg;

    s1_t   s1_next;
    s1_t   s1_reg;
    side_t s2_reg;
    side_t s3_reg;
    side_t s4_reg;

    logic [7:0]          pix_min;
    logic [SR-1:0][7:0]  col_word;
    logic [SR-1:0][7:0]  col_wdata;
    logic                mem_we;
    logic [7:0]          col_min;
    logic [SR-1:0][7:0]  hist_reg;
    logic [7:0]          win_min;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    // A write to any named register restarts the frame.
    assign cfg_hit = cfg_valid && cfg_ready &&
                     (cfg_index == dcmf_pkg::CFG_FRAME_WIDTH ||
                      cfg_index == dcmf_pkg::CFG_FRAME_HEIGHT ||
                      cfg_index == dcmf_pkg::CFG_WINDOW_RADIUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dcmf_pkg::RESET_WIDTH;
            height_reg <= dcmf_pkg::RESET_HEIGHT;
            radius_reg <= dcmf_pkg::RESET_RADIUS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dcmf_pkg::CFG_FRAME_WIDTH:   width_reg  <= cfg_data;
                dcmf_pkg::CFG_FRAME_HEIGHT:  height_reg <= cfg_data;
                dcmf_pkg::CFG_WINDOW_RADIUS: radius_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = PW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = PW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = PW'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = PW'(1);
        end
        else if (32'(height_reg) > dcmf_pkg::HEIGHT_MAX)
        begin
            eff_h = PW'(dcmf_pkg::HEIGHT_MAX);
        end
        else
        begin
            eff_h = PW'(height_reg);
        end

        if (32'(radius_reg) > MAX_RADIUS)
        begin
            eff_r = RAD_W'(MAX_RADIUS);
        end
        else
        begin
            eff_r = RAD_W'(radius_reg);
        end
    end

    assign two_r  = {eff_r, 1'b0};
    assign span_w = eff_w + PW'(eff_r);
    assign span_h = eff_h + PW'(eff_r);

    // ----------------------------------------------------------- handshakes
    assign en5       = !out_vld_reg || !dark_stall;
    assign en4       = !s4_vld_reg || en5;
    assign en3       = !s3_vld_reg || en4;
    assign en2       = !s2_vld_reg || en3;
    assign en1       = !s1_vld_reg || en2;
    assign pix_stall = !en1;
    assign accept    = pix_valid && en1;

    // -------------------------------------------------------- raster walk
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == span_w - PW'(1))
            begin
                col_next = '0;
                if (row_reg == span_h - PW'(1))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + PW'(1);
                end
            end
            else
            begin
                col_next = col_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Per-item values fixed at the accepting edge.
    always_comb
    begin
        pix_min = pix_data.blue;
        if (pix_data.green < pix_min)
        begin
            pix_min = pix_data.green;
        end
        if (pix_data.red < pix_min)
        begin
            pix_min = pix_data.red;
        end

        s1_next.in_col = col_reg < eff_w;
        s1_next.addr   = col_reg[AW-1:0];
        s1_next.v      = (s1_next.in_col && row_reg < eff_h) ? pix_min
                                                             : dcmf_pkg::FILL_VALUE;
        // Only rows of the current frame count in the vertical window.
        if (!s1_next.in_col)
        begin
            s1_next.vlim = '0;
        end
        else if (row_reg < PW'(two_r))
        begin
            s1_next.vlim = LIM_W'(row_reg);
        end
        else
        begin
            s1_next.vlim = LIM_W'(two_r);
        end
        if (col_reg < PW'(two_r))
        begin
            s1_next.hlim = LIM_W'(col_reg);
        end
        else
        begin
            s1_next.hlim = LIM_W'(two_r);
        end
        s1_next.emit = (col_reg >= PW'(eff_r)) && (row_reg >= PW'(eff_r));
        s1_next.fend = (col_reg == span_w - PW'(1)) && (row_reg == span_h - PW'(1));
    end

    // -------------------------------------------------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_vld_reg <= accept;
            end
            if (en2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (en3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (en4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (en5)
            begin
                out_vld_reg <= s4_vld_reg && s4_reg.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= '{hlim: s1_reg.hlim, emit: s1_reg.emit, fend: s1_reg.fend};
        end
        if (en3)
        begin
            s3_reg <= s2_reg;
        end
        if (en4)
        begin
            s4_reg <= s3_reg;
        end
        if (en5)
        begin
            fend_reg <= s4_reg.fend;
        end
    end

    // ------------------------------------------------ column history store
    dcmf_column_store #(
        .DEPTH  (MAX_WIDTH),
        .WORD_W (SR * 8)
    ) u_column_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (s1_next.addr),
        .wr_en   (mem_we),
        .wr_addr (s1_reg.addr),
        .wr_data (col_wdata),
        .rd_data (col_word)
    );

    // The newest row enters at entry zero as the item leaves the first stage.
    assign col_wdata = {col_word[SR-2:0], s1_reg.v};
    assign mem_we    = s1_vld_reg && en2 && s1_reg.in_col;

    dcmf_window_min #(
        .HIST  (SR),
        .LIM_W (LIM_W)
    ) u_vert_min (
        .clk     (clk),
        .en_a    (en2),
        .en_b    (en3),
        .head    (s1_reg.v),
        .hist    (col_word),
        .lim     (s1_reg.vlim),
        .min_out (col_min)
    );

    // ------------------------------------------------ horizontal window
    always_ff @(posedge clk)
    begin
        if (s3_vld_reg && en4)
        begin
            hist_reg <= {hist_reg[SR-2:0], col_min};
        end
    end

    dcmf_window_min #(
        .HIST  (SR),
        .LIM_W (LIM_W)
    ) u_horiz_min (
        .clk     (clk),
        .en_a    (en4),
        .en_b    (en5),
        .head    (col_min),
        .hist    (hist_reg),
        .lim     (s3_reg.hlim),
        .min_out (win_min)
    );

    assign dark_valid           = out_vld_reg;
    assign dark_data.dark_value = win_min;
    assign dark_data.frame_end  = fend_reg;

    // ---------------------------------------------------------- assertions
    `DCMF_ASSERT_IMPL(a_col_in_span, 1'b1, col_reg < span_w, "column position out of span")
    `DCMF_ASSERT_IMPL(a_row_in_span, 1'b1, row_reg < span_h, "row position out of span")
    `DCMF_ASSERT_NEXT(a_accept_fills_s1, accept, s1_vld_reg, "accepted pixel lost")
    `DCMF_ASSERT_NEXT(a_cfg_restarts, cfg_hit,
        col_reg == '0 && row_reg == '0, "configuration write did not restart frame")

endmodule

`default_nettype wire

// ----- hw/rtl/dcmf_column_store.sv -----
// ----------------------------------------------------------------------------
// dcmf_column_store
// Per-column history of channel minima, one word per column, with forwarding
// of a write that lands on the address being read in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_column_store #(
    parameter int DEPTH  = 2048,
    parameter int WORD_W = 240
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WORD_W-1:0]        wr_data,
    output logic      [WORD_W-1:0]        rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] mem_q_reg;
    logic              fwd_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // A read issued in the same cycle as a write to the same column would
    // return the old word, so the written word is kept and used instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dcmf_window_min.sv -----
// ----------------------------------------------------------------------------
// dcmf_window_min
// Masked minimum of a newest value and its history, as a two-stage
// registered tree: groups of eight, then the group results.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_window_min #(
    parameter int HIST  = 30,
    parameter int LIM_W = 5
) (
    input  wire logic                 clk,
    input  wire logic                 en_a,
    input  wire logic                 en_b,
    input  wire logic [7:0]           head,
    input  wire logic [HIST-1:0][7:0] hist,
    input  wire logic [LIM_W-1:0]     lim,
    output logic      [7:0]           min_out
);

    localparam int N = HIST + 1;
    localparam int G = (N + 7) / 8;

    logic [G*8-1:0][7:0] padded;
    logic [G-1:0][7:0]   grp_min;
    logic [G-1:0][7:0]   grp_reg;
    logic [7:0]          all_min;
    logic [7:0]          min_reg;

    // History entry k takes part only when k is below the limit.
    always_comb
    begin
        padded = '{default: dcmf_pkg::FILL_VALUE};
        padded[0] = head;
        for (int k = 0; k < HIST; k++)
        begin
            if (LIM_W'(k) < lim)
            begin
                padded[k+1] = hist[k];
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < G; g++)
        begin
            grp_min[g] = dcmf_pkg::FILL_VALUE;
            for (int j = 0; j < 8; j++)
            begin
                if (padded[g*8+j] < grp_min[g])
                begin
                    grp_min[g] = padded[g*8+j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            grp_reg <= grp_min;
        end
    end

    always_comb
    begin
        all_min = dcmf_pkg::FILL_VALUE;
        for (int g = 0; g < G; g++)
        begin
            if (grp_reg[g] < all_min)
            begin
                all_min = grp_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            min_reg <= all_min;
        end
    end

    assign min_out = min_reg;

endmodule

`default_nettype wire
